>>> src/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam int PAGE_COUNT_MAX = 4096;

  localparam int BASE_W  = 40;
  localparam int INDEX_W = $clog2(PAGE_COUNT_MAX);
  localparam int COUNT_W = INDEX_W + 1;
  localparam int ORDER_W = 4;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] granted_page;
    logic [COUNT_W-1:0] free_page_total;
  } result_t;

endpackage

>>> src/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bpa_core.sv
`timescale 1ns / 1ps

module bpa_core #(
  parameter int ORDER_COUNT    = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bpa_pkg::BASE_W-1:0]   base,
  input  logic [bpa_pkg::COUNT_W-1:0]  count,
  input  logic                         start,
  input  logic                         operation,
  input  logic [bpa_pkg::ORDER_W-1:0]  block_order,
  input  logic [bpa_pkg::INDEX_W-1:0]  page_index,
  output logic                         busy,
  output logic                         done,
  output bpa_pkg::result_t             res
);

  localparam int PAGE_COUNT_MAX = bpa_pkg::PAGE_COUNT_MAX;
  localparam int PW  = $clog2(PAGE_COUNT_MAX);
  localparam int LW  = PW + 1;
  localparam int MW  = $clog2(ORDER_COUNT + 1);
  localparam int OIW = $clog2(ORDER_COUNT);
  localparam int AW  = bpa_pkg::BASE_W + 1;
  localparam int DW  = AW + 1;
  localparam int CW  = 18;
  localparam int FW  = bpa_pkg::COUNT_W;
  localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT_MAX);
  localparam logic [MW-1:0] MARK_ALLOC = MW'(ORDER_COUNT);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_SCAN, S_U_RD, S_U_WR, S_A_SPLIT, S_P_WR0, S_P_WR1,
    S_F_ABS, S_F_CHK, S_F_MK, S_M_BUD, S_M_MARK, S_M_NEXT, S_F_END, S_DONE
  } state_t;

  state_t state;
  logic [PW:0]    clr;
  logic           op;
  logic [MW-1:0]  ord_req;
  logic [MW-1:0]  cur_ord;
  logic [PW-1:0]  pg;
  logic [PW-1:0]  cur;
  logic [LW-1:0]  hq;
  logic [AW-1:0]  abs_page;
  logic [bpa_pkg::INDEX_W-1:0] idx;
  logic           rng_bad;
  logic [1:0]     status;
  logic [FW-1:0]  free_pages;
  logic [LW-1:0]  head [ORDER_COUNT];

  logic           mark_we, next_we, prev_we;
  logic [PW-1:0]  mark_waddr, next_waddr, prev_waddr, mark_raddr;
  logic [MW-1:0]  mark_wdata, mark_rd;
  logic [LW-1:0]  next_wdata, prev_wdata, next_rd, prev_rd;

  logic [CW-1:0]  cnt_eff;
  logic [LW-1:0]  head_sel;
  logic [FW-1:0]  size;
  logic [AW-1:0]  bud;
  logic [DW-1:0]  bud_off, end_off;
  logic           bud_out;
  logic [CW-1:0]  split_page;

  function automatic logic inr(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  always_comb begin
    cnt_eff  = (CW'(count) > CW'(PAGE_COUNT_MAX)) ? CW'(PAGE_COUNT_MAX) : CW'(count);
    head_sel = head[cur_ord[OIW-1:0]];
    size     = FW'(1) << ord_req;
    bud      = abs_page ^ (AW'(1) << cur_ord);
    bud_off  = {1'b0, bud} - DW'(base);
    bud_out  = bud_off[DW-1] || (bud_off[AW-1:0] >= AW'(cnt_eff));
    end_off  = {1'b0, abs_page} - DW'(base);
    split_page = CW'(pg) + (CW'(1) << (cur_ord - MW'(1)));
  end

  // memory ports
  always_comb begin
    mark_we = 1'b0; mark_waddr = cur; mark_wdata = MARK_ALLOC;
    next_we = 1'b0; next_waddr = cur; next_wdata = NIL;
    prev_we = 1'b0; prev_waddr = cur; prev_wdata = NIL;
    mark_raddr = (state == S_F_CHK) ? PW'(idx) : bud_off[PW-1:0];
    unique case (state)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr[PW-1:0];
      end
      S_U_WR: begin
        mark_we    = 1'b1;
        next_we    = inr(prev_rd);
        next_waddr = prev_rd[PW-1:0];
        next_wdata = next_rd;
        prev_we    = inr(next_rd);
        prev_waddr = next_rd[PW-1:0];
        prev_wdata = prev_rd;
      end
      S_P_WR0: begin
        mark_we    = 1'b1;
        mark_wdata = cur_ord;
        next_we    = 1'b1;
        next_wdata = inr(head_sel) ? head_sel : NIL;
        prev_we    = 1'b1;
      end
      S_P_WR1: begin
        prev_we    = inr(hq);
        prev_waddr = hq[PW-1:0];
        prev_wdata = LW'(cur);
      end
      default: ;
    endcase
  end

  bpa_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT_MAX)) u_mark (
    .clk, .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rd)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT_MAX)) u_next (
    .clk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(cur), .rdata(next_rd)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT_MAX)) u_prev (
    .clk, .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(cur), .rdata(prev_rd)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      done       <= 1'b0;
      free_pages <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head[i] <= NIL;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (PW+1)'(PAGE_COUNT_MAX - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op  <= operation;
            idx <= page_index;
            ord_req <= MW'(block_order);
            cur_ord <= MW'(block_order);
            if (32'(block_order) >= ORDER_COUNT) begin
              status <= (operation == bpa_pkg::OP_FREE) ? bpa_pkg::STATUS_BAD_FREE
                                                        : bpa_pkg::STATUS_NO_SPACE;
              state  <= S_DONE;
            end else if (operation == bpa_pkg::OP_FREE) begin
              state <= S_F_ABS;
            end else begin
              state <= S_A_SCAN;
            end
          end
        end
        S_A_SCAN: begin
          if (cur_ord == MARK_ALLOC) begin
            status <= bpa_pkg::STATUS_NO_SPACE;
            state  <= S_DONE;
          end else if (inr(head_sel)) begin
            pg    <= head_sel[PW-1:0];
            cur   <= head_sel[PW-1:0];
            state <= S_U_RD;
          end else begin
            cur_ord <= cur_ord + 1'b1;
          end
        end
        S_U_RD: state <= S_U_WR;
        S_U_WR: begin
          if (!inr(prev_rd)) begin
            head[cur_ord[OIW-1:0]] <= inr(next_rd) ? next_rd : NIL;
          end
          state <= (op == bpa_pkg::OP_FREE) ? S_M_NEXT : S_A_SPLIT;
        end
        S_A_SPLIT: begin
          if (cur_ord > ord_req) begin
            cur_ord <= cur_ord - 1'b1;
            if (split_page < CW'(PAGE_COUNT_MAX)) begin
              cur   <= split_page[PW-1:0];
              state <= S_P_WR0;
            end
          end else begin
            free_pages <= free_pages - size;
            status     <= bpa_pkg::STATUS_OK;
            state      <= S_DONE;
          end
        end
        S_P_WR0: begin
          hq <= head_sel;
          head[cur_ord[OIW-1:0]] <= LW'(cur);
          state <= S_P_WR1;
        end
        S_P_WR1: begin
          if (op == bpa_pkg::OP_FREE) begin
            free_pages <= free_pages + size;
            status     <= bpa_pkg::STATUS_OK;
            state      <= S_DONE;
          end else begin
            state <= S_A_SPLIT;
          end
        end
        S_F_ABS: begin
          abs_page <= AW'(base) + AW'(idx);
          rng_bad  <= (CW'(idx) + (CW'(1) << ord_req)) > cnt_eff;
          state    <= S_F_CHK;
        end
        S_F_CHK: begin
          // mark read of the first page is issued here
          if (rng_bad || ((abs_page & ((AW'(1) << ord_req) - AW'(1))) != '0)) begin
            status <= bpa_pkg::STATUS_BAD_FREE;
            state  <= S_DONE;
          end else begin
            state <= S_F_MK;
          end
        end
        S_F_MK: begin
          if (mark_rd != MARK_ALLOC) begin
            status <= bpa_pkg::STATUS_BAD_FREE;
            state  <= S_DONE;
          end else begin
            state <= S_M_BUD;
          end
        end
        S_M_BUD: begin
          if (32'(cur_ord) >= ORDER_COUNT - 1 || bud_out) begin
            state <= S_F_END;
          end else begin
            cur   <= bud_off[PW-1:0];
            state <= S_M_MARK;
          end
        end
        S_M_MARK: begin
          state <= (mark_rd == cur_ord) ? S_U_RD : S_F_END;
        end
        S_M_NEXT: begin
          cur_ord  <= cur_ord + 1'b1;
          abs_page <= abs_page & ~((AW'(1) << (cur_ord + 1'b1)) - AW'(1));
          state    <= S_M_BUD;
        end
        S_F_END: begin
          if (end_off[DW-1] || (end_off[AW-1:0] >= AW'(PAGE_COUNT_MAX))) begin
            status <= bpa_pkg::STATUS_BAD_FREE;
            state  <= S_DONE;
          end else begin
            cur   <= end_off[PW-1:0];
            state <= S_P_WR0;
          end
        end
        S_DONE: begin
          done                <= 1'b1;
          res.status          <= status;
          res.granted_page    <= (status == bpa_pkg::STATUS_OK && op == bpa_pkg::OP_ALLOC)
                                 ? bpa_pkg::INDEX_W'(pg) : '0;
          res.free_page_total <= free_pages;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/buddy_page_allocator.sv
`timescale 1ns / 1ps

// Binary buddy page allocator over one segment. Pulse start with busy low to
// issue an allocate or free transaction; busy stays high until done pulses for
// one cycle with status, granted_page and free_page_total, and the receiver
// must take the result in that cycle. A transaction is handled by a small
// sequencer around page-mark and link memories with one write and one
// registered read port each: an allocate skips empty orders and pushes the
// split-off halves onto their free lists, and a free merges with its buddy
// until the top order is reached or the buddy lies outside the segment or is
// not free at that order. After reset the page-mark memory is swept to
// "allocated" with busy high. Configuration writes are always ready and
// belong only in idle periods.
module buddy_page_allocator #(
  parameter int ORDER_COUNT    = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [bpa_pkg::ORDER_W-1:0]  block_order,
  input  logic [bpa_pkg::INDEX_W-1:0]  page_index,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [bpa_pkg::INDEX_W-1:0]  granted_page,
  output logic [bpa_pkg::COUNT_W-1:0]  free_page_total,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [bpa_pkg::BASE_W-1:0]   cfg_data
);

  logic [bpa_pkg::BASE_W-1:0]  base;
  logic [bpa_pkg::COUNT_W-1:0] count;
  bpa_pkg::result_t            res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      count <= bpa_pkg::COUNT_W'(bpa_pkg::PAGE_COUNT_MAX);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpa_pkg::CFG_BASE:  base  <= cfg_data;
        bpa_pkg::CFG_COUNT: count <= cfg_data[bpa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bpa_core #(.ORDER_COUNT(ORDER_COUNT)) u_core (
    .clk, .rst, .base, .count, .start, .operation, .block_order, .page_index,
    .busy, .done, .res
  );

  assign status          = res.status;
  assign granted_page    = res.granted_page;
  assign free_page_total = res.free_page_total;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != bpa_pkg::STATUS_OK) |-> granted_page == '0)
    else $error("nonzero grant on failed transaction");

endmodule

>>> tb/buddy_page_allocator_test.sv
`timescale 1ns / 1ps

module buddy_page_allocator_test;

  localparam int PAGES      = bpa_pkg::PAGE_COUNT_MAX;
  localparam int ORDERS     = 11;
  localparam int MARK_TAKEN = ORDERS;
  localparam int NIL        = PAGES;

  // Tracks free lists and page marks, predicts every transaction's result.
  class alloc_scoreboard;
    logic [bpa_pkg::BASE_W-1:0] base;
    int unsigned       count;
    int unsigned       mark[PAGES];
    int unsigned       nxt[PAGES];
    int unsigned       prv[PAGES];
    int unsigned       head[ORDERS];
    int unsigned       len[ORDERS];
    int unsigned       free_pages;
    bpa_pkg::result_t  expected_q[$];
    int                errors;
    int                checked;

    function new();
      base = '0;
      count = PAGES;
      foreach (mark[i]) begin
        mark[i] = MARK_TAKEN;
        nxt[i] = NIL;
        prv[i] = NIL;
      end
      foreach (head[i]) begin
        head[i] = NIL;
        len[i] = 0;
      end
      free_pages = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void push_block(int unsigned ord, int unsigned p);
      int unsigned h;
      h = head[ord];
      prv[p] = NIL;
      nxt[p] = (h < PAGES) ? h : NIL;
      if (h < PAGES) prv[h] = p;
      head[ord] = p;
      len[ord] = (len[ord] + 1) & 13'h1fff;
    endfunction

    function void unlink_block(int unsigned ord, int unsigned p);
      int unsigned n, pr;
      n = nxt[p];
      pr = prv[p];
      if (pr < PAGES) nxt[pr] = n;
      else head[ord] = (n < PAGES) ? n : NIL;
      if (n < PAGES) prv[n] = pr;
      len[ord] = (len[ord] - 1) & 13'h1fff;
    endfunction

    function logic [1:0] take_block(int unsigned ord, output int unsigned granted);
      int unsigned i, p, b;
      granted = 0;
      i = ord;
      while (i < ORDERS && head[i] >= PAGES) i++;
      if (i >= ORDERS) return bpa_pkg::STATUS_NO_SPACE;
      p = head[i];
      unlink_block(i, p);
      mark[p] = MARK_TAKEN;
      while (i > ord) begin
        i--;
        b = p + (1 << i);
        if (b < PAGES) begin
          push_block(i, b);
          mark[b] = i;
        end
      end
      free_pages = (free_pages - (1 << ord)) & 13'h1fff;
      granted = p;
      return bpa_pkg::STATUS_OK;
    endfunction

    function logic [1:0] give_block(int unsigned ord, int unsigned idx);
      longint unsigned cnt, size, abs_page, bud, rel;
      int unsigned p;
      cnt = (count > PAGES) ? PAGES : count;
      if (ord >= ORDERS) return bpa_pkg::STATUS_BAD_FREE;
      size = longint'(1) << ord;
      if (idx + size > cnt) return bpa_pkg::STATUS_BAD_FREE;
      abs_page = longint'(base) + idx;
      if ((abs_page & (size - 1)) != 0) return bpa_pkg::STATUS_BAD_FREE;
      if (mark[idx] != MARK_TAKEN) return bpa_pkg::STATUS_BAD_FREE;
      while (ord < ORDERS - 1) begin
        bud = abs_page ^ (longint'(1) << ord);
        if (bud < longint'(base) || bud >= longint'(base) + cnt) break;
        rel = bud - longint'(base);
        if (mark[rel] != ord) break;
        unlink_block(ord, 32'(rel));
        mark[rel] = MARK_TAKEN;
        ord++;
        abs_page &= ~((longint'(1) << ord) - 1);
      end
      p = 32'(abs_page - longint'(base));
      if (p >= PAGES) return bpa_pkg::STATUS_BAD_FREE;
      push_block(ord, p);
      mark[p] = ord;
      free_pages = 32'((free_pages + size) & 13'h1fff);
      return bpa_pkg::STATUS_OK;
    endfunction

    function bpa_pkg::result_t note_request(logic op, logic [bpa_pkg::ORDER_W-1:0] ord,
                                            logic [bpa_pkg::INDEX_W-1:0] idx);
      bpa_pkg::result_t r;
      int unsigned g;
      g = 0;
      if (op == bpa_pkg::OP_ALLOC) begin
        r.status = (ord < ORDERS) ? take_block(32'(ord), g) : bpa_pkg::STATUS_NO_SPACE;
      end else begin
        r.status = give_block(32'(ord), 32'(idx));
      end
      if (r.status != bpa_pkg::STATUS_OK) g = 0;
      r.granted_page = bpa_pkg::INDEX_W'(g);
      r.free_page_total = bpa_pkg::COUNT_W'(free_pages);
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(bpa_pkg::result_t got);
      bpa_pkg::result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d page=%0d total=%0d",
                 $time, got.status, got.granted_page, got.free_page_total);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      end
      if (got.granted_page !== e.granted_page) begin
        errors++;
        $display("%0t: granted_page expected %0d actual %0d",
                 $time, e.granted_page, got.granted_page);
      end
      if (got.free_page_total !== e.free_page_total) begin
        errors++;
        $display("%0t: free_page_total expected %0d actual %0d",
                 $time, e.free_page_total, got.free_page_total);
      end
    endfunction
  endclass

  logic                         clk = 0;
  logic                         rst = 1;
  logic                         start = 0;
  logic                         busy;
  logic                         operation = bpa_pkg::OP_ALLOC;
  logic [bpa_pkg::ORDER_W-1:0]  block_order = '0;
  logic [bpa_pkg::INDEX_W-1:0]  page_index = '0;
  logic                         done;
  logic [1:0]                   status;
  logic [bpa_pkg::INDEX_W-1:0]  granted_page;
  logic [bpa_pkg::COUNT_W-1:0]  free_page_total;
  logic                         cfg_valid = 0;
  logic                         cfg_ready;
  logic                         cfg_index = bpa_pkg::CFG_BASE;
  logic [bpa_pkg::BASE_W-1:0]   cfg_data = '0;

  alloc_scoreboard sb = new();
  int unsigned held_page[$];
  int unsigned held_order[$];
  bit gaps_on = 1;
  int items = 0;
  int cfg_writes = 0;

  buddy_page_allocator dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result({status, granted_page, free_page_total});
  end

  task automatic issue(input logic op, input logic [bpa_pkg::ORDER_W-1:0] ord,
                       input logic [bpa_pkg::INDEX_W-1:0] idx);
    bpa_pkg::result_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
    start = 1;
    operation = op;
    block_order = ord;
    page_index = idx;
    do @(posedge clk); while (busy);
    r = sb.note_request(op, ord, idx);
    items++;
    if (op == bpa_pkg::OP_ALLOC && r.status == bpa_pkg::STATUS_OK) begin
      held_page.push_back(32'(r.granted_page));
      held_order.push_back(32'(ord));
    end
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [bpa_pkg::BASE_W-1:0] data);
    drain();
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bpa_pkg::CFG_BASE) sb.base = data;
    else sb.count = 32'(data[bpa_pkg::COUNT_W-1:0]);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic release_held();
    while (held_page.size() != 0) begin
      issue(bpa_pkg::OP_FREE, bpa_pkg::ORDER_W'(held_order.pop_back()),
            bpa_pkg::INDEX_W'(held_page.pop_back()));
    end
  endtask

  task automatic random_run(int n);
    int k, sel;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        issue(bpa_pkg::OP_ALLOC,
              bpa_pkg::ORDER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 10)
                                                            : $urandom_range(0, 3)),
              '0);
      end else if (sel < 85 && held_page.size() != 0) begin
        sel = $urandom_range(0, held_page.size() - 1);
        issue(bpa_pkg::OP_FREE, bpa_pkg::ORDER_W'(held_order[sel]),
              bpa_pkg::INDEX_W'(held_page[sel]));
        held_page.delete(sel);
        held_order.delete(sel);
      end else begin
        issue(1'($urandom_range(0, 1)), bpa_pkg::ORDER_W'($urandom_range(0, 15)),
              bpa_pkg::INDEX_W'($urandom_range(0, 4095)));
      end
    end
  endtask

  initial begin
    int p, o;
    repeat (8) @(negedge clk);
    rst = 0;

    write_reg(bpa_pkg::CFG_BASE, '0);
    write_reg(bpa_pkg::CFG_COUNT, 40'd4096);

    // nothing free yet, bad orders, range and alignment rejects
    issue(bpa_pkg::OP_ALLOC, 4'd0, 12'd0);
    issue(bpa_pkg::OP_ALLOC, 4'd11, 12'd0);
    issue(bpa_pkg::OP_ALLOC, 4'd15, 12'd4095);
    issue(bpa_pkg::OP_FREE, 4'd11, 12'd0);
    issue(bpa_pkg::OP_FREE, 4'd15, 12'd0);
    issue(bpa_pkg::OP_FREE, 4'd1, 12'd4095);
    issue(bpa_pkg::OP_FREE, 4'd10, 12'd3073);
    issue(bpa_pkg::OP_FREE, 4'd1, 12'd1);
    for (p = 0; p < 4; p++) issue(bpa_pkg::OP_FREE, 4'd10, 12'(p * 1024));
    issue(bpa_pkg::OP_FREE, 4'd10, 12'd0);          // head already free
    issue(bpa_pkg::OP_ALLOC, 4'd0, 12'd0);
    issue(bpa_pkg::OP_ALLOC, 4'd10, 12'd0);
    issue(bpa_pkg::OP_ALLOC, 4'd3, 12'd0);
    issue(bpa_pkg::OP_FREE, 4'd0, 12'd5);           // inner page of a free block
    issue(bpa_pkg::OP_ALLOC, 4'd0, 12'd0);
    issue(bpa_pkg::OP_ALLOC, 4'd0, 12'd0);
    issue(bpa_pkg::OP_FREE, 4'd0, 12'd4095);
    release_held();

    random_run(330);

    release_held();
    write_reg(bpa_pkg::CFG_BASE, 40'd3);
    write_reg(bpa_pkg::CFG_COUNT, 40'd1000);
    random_run(280);

    release_held();
    write_reg(bpa_pkg::CFG_BASE, 40'hff_ffff_f000);
    write_reg(bpa_pkg::CFG_COUNT, 40'd4096);
    random_run(280);

    release_held();
    write_reg(bpa_pkg::CFG_COUNT, 40'd1);
    for (o = 0; o < 3; o++) issue(bpa_pkg::OP_FREE, 4'(o), 12'd0);
    random_run(80);

    release_held();
    write_reg(bpa_pkg::CFG_BASE, {8'($urandom_range(0, 255)), 20'($urandom()),
                                  12'($urandom_range(0, 4095))});
    write_reg(bpa_pkg::CFG_COUNT, 40'($urandom_range(1, 4096)));
    random_run(280);

    release_held();
    write_reg(bpa_pkg::CFG_BASE, '0);
    write_reg(bpa_pkg::CFG_COUNT, 40'd4096);
    gaps_on = 0;
    random_run(330);

    drain();
    $display("%0d transactions checked against %0d predicted, %0d register writes,",
             sb.checked, items, cfg_writes);
    $display("six segment layouts including base and size extremes");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[buddy_page_allocator] OK");
    end else begin
      $display("[buddy_page_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[buddy_page_allocator] ERROR");
    $finish;
  end

endmodule
